[src/descending_time_record_sorter_macros.svh]
// Assertion macros used by the descending time record sorter RTL.
`ifndef DESCENDING_TIME_RECORD_SORTER_MACROS_SVH
`define DESCENDING_TIME_RECORD_SORTER_MACROS_SVH

`ifndef SYNTHESIS
// Check prop at every clock edge outside reset.
`define DTRS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that cons holds in the cycle after ante.
`define DTRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DTRS_ASSERT(lbl, prop, msg)
`define DTRS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[src/dtrs_pkg.sv]
// Types and constants of the descending time record sorter.
package dtrs_pkg;

    localparam int TIME_W = 34;
    localparam int TAG_W  = 16;

    // Input word: one record of the list.
    typedef struct packed {
        logic [TIME_W-1:0] mod_time;
        logic [TAG_W-1:0]  entry_tag;
        logic              last_entry;
    } in_word_t;

    // Result word: one record of the sorted list.
    typedef struct packed {
        logic [TIME_W-1:0] sorted_time;
        logic [TAG_W-1:0]  sorted_tag;
        logic              last_out;
        logic              overflow;
    } out_word_t;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic drain;
    } cell_ctl_t;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } state_t;

endpackage

[src/dtrs_cell.sv]
// One cell of the sorting chain: holds a record, inserts or shifts it along.
module dtrs_cell #(
    parameter int TAG_KEEP = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  dtrs_pkg::cell_ctl_t       ctl,
    input  logic [dtrs_pkg::TIME_W-1:0] new_time,
    input  logic [TAG_KEEP-1:0]       new_tag,
    input  logic                      prev_ge,
    input  logic                      prev_valid,
    input  logic [dtrs_pkg::TIME_W-1:0] prev_time,
    input  logic [TAG_KEEP-1:0]       prev_tag,
    input  logic                      next_valid,
    input  logic [dtrs_pkg::TIME_W-1:0] next_time,
    input  logic [TAG_KEEP-1:0]       next_tag,
    output logic                      ge,
    output logic                      valid,
    output logic [dtrs_pkg::TIME_W-1:0] time_key,
    output logic [TAG_KEEP-1:0]       tag
);
    import dtrs_pkg::*;

    logic                valid_reg, valid_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [TAG_KEEP-1:0] tag_reg, tag_next;

    // New record goes after this one when its key is not newer.
    assign ge = valid_reg && (time_reg >= new_time);

    // Take the new record, the left neighbor's record, or the right one.
    always_comb
    begin
        valid_next = valid_reg;
        time_next  = time_reg;
        tag_next   = tag_reg;
        if (ctl.drain)
        begin
            valid_next = next_valid;
            time_next  = next_time;
            tag_next   = next_tag;
        end
        else if (ctl.insert)
        begin
            if (!prev_ge)
            begin
                valid_next = prev_valid;
                time_next  = prev_time;
                tag_next   = prev_tag;
            end
            else if (!ge)
            begin
                valid_next = 1'b1;
                time_next  = new_time;
                tag_next   = new_tag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        time_reg <= time_next;
        tag_reg  <= tag_next;
    end

    assign valid    = valid_reg;
    assign time_key = time_reg;
    assign tag      = tag_reg;

endmodule

[src/descending_time_record_sorter.sv]
// Stable descending insertion sorter: a chain of DEPTH cells, newest record first.
// All cells compare against each record taken and shift in parallel.
// On the record marked last, its N held words come out one per cycle from cell 0,
// the first in the cycle after it is taken; busy stays high while they come out.
// Results cannot be stalled.
// Reset (rst_n low, asynchronous) empties every cell and clears count and overflow.
`include "descending_time_record_sorter_macros.svh"
module descending_time_record_sorter #(
    parameter int DEPTH    = 32,
    parameter int TAG_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  dtrs_pkg::in_word_t  item,
    output logic                result_strobe,
    output dtrs_pkg::out_word_t result
);
    import dtrs_pkg::*;

    localparam int TAG_KEEP = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam int CNT_W    = $clog2(DEPTH + 1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              dropped_reg, dropped_next;

    logic              accept;
    logic              full;
    cell_ctl_t         ctl;

    logic                cell_ge    [DEPTH];
    logic                cell_valid [DEPTH];
    logic [TIME_W-1:0]   cell_time  [DEPTH];
    logic [TAG_KEEP-1:0] cell_tag   [DEPTH];

    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(DEPTH));

    // Next state, count and overflow flag.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        case (state_reg)
            ST_FILL:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (item.last_entry)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                count_next = count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    state_next   = ST_FILL;
                    dropped_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    // Outputs and cell control.
    always_comb
    begin
        busy          = 1'b0;
        result_strobe = 1'b0;
        ctl.insert    = 1'b0;
        ctl.drain     = 1'b0;
        case (state_reg)
            ST_FILL:
            begin
                ctl.insert = accept && !full;
            end
            ST_DRAIN:
            begin
                busy          = 1'b1;
                result_strobe = 1'b1;
                ctl.drain     = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_FILL;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    // Build the chain; cell 0 holds the newest record.
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic                pge;
            logic                pvalid;
            logic [TIME_W-1:0]   ptime;
            logic [TAG_KEEP-1:0] ptag;
            logic                nvalid;
            logic [TIME_W-1:0]   ntime;
            logic [TAG_KEEP-1:0] ntag;

            if (gi == 0)
            begin : g_head
                assign pge    = 1'b1;
                assign pvalid = 1'b0;
                assign ptime  = '0;
                assign ptag   = '0;
            end
            else
            begin : g_body
                assign pge    = cell_ge[gi-1];
                assign pvalid = cell_valid[gi-1];
                assign ptime  = cell_time[gi-1];
                assign ptag   = cell_tag[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign nvalid = 1'b0;
                assign ntime  = '0;
                assign ntag   = '0;
            end
            else
            begin : g_link
                assign nvalid = cell_valid[gi+1];
                assign ntime  = cell_time[gi+1];
                assign ntag   = cell_tag[gi+1];
            end

            dtrs_cell #(
                .TAG_KEEP (TAG_KEEP)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .new_time   (item.mod_time),
                .new_tag    (item.entry_tag[TAG_KEEP-1:0]),
                .prev_ge    (pge),
                .prev_valid (pvalid),
                .prev_time  (ptime),
                .prev_tag   (ptag),
                .next_valid (nvalid),
                .next_time  (ntime),
                .next_tag   (ntag),
                .ge         (cell_ge[gi]),
                .valid      (cell_valid[gi]),
                .time_key   (cell_time[gi]),
                .tag        (cell_tag[gi])
            );
        end
    endgenerate

    // Present the head cell as the result word.
    always_comb
    begin
        result.sorted_time = cell_time[0];
        result.sorted_tag  = TAG_W'(cell_tag[0]);
        result.last_out    = result_strobe && (count_reg == CNT_W'(1));
        result.overflow    = result_strobe && dropped_reg;
    end

    `DTRS_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "held count above depth")
    `DTRS_ASSERT(a_head_valid, !result_strobe || cell_valid[0], "result word from empty cell")
    `DTRS_ASSERT_NEXT(a_last_ends, result.last_out, !busy && !cell_valid[0],
        "store not empty after final word")
    `DTRS_ASSERT_NEXT(a_last_starts, accept && item.last_entry, result_strobe,
        "no result after final record")

endmodule

[test/descending_time_record_sorter_test.sv]
// Testbench for descending_time_record_sorter: stable newest-first sort of record lists.
`timescale 1ns / 100ps
module descending_time_record_sorter_test;
    import dtrs_pkg::*;

    localparam int DEPTH       = 32;
    localparam int TAG_BITS    = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [TAG_W-1:0]  TAG_KEEP = TAG_W'((64'd1 << TAG_BITS) - 64'd1);

    // Key patterns for random lists.
    typedef enum int {
        KEYS_WIDE,
        KEYS_TIED,
        KEYS_TOP,
        KEYS_EDGES
    } key_style_t;

    // Record as held in the sorted store.
    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic [TAG_W-1:0]  tag;
    } record_t;

    // Word waiting to be sent, with how it is to be paced.
    typedef struct {
        in_word_t word;
        int       idle_pct;
        bit       drain_first;
    } send_slot_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    in_word_t  item = '0;
    logic      busy;
    logic      result_strobe;
    out_word_t result;

    send_slot_t records_to_send[$];
    record_t    held_records[$];
    bit         records_dropped = 1'b0;
    out_word_t  sorted_due[$];
    int         results_due = 0;
    int         results_seen = 0;
    int         errors = 0;
    int         cycles = 0;
    int         cur_idle = 29;
    bit         hold_next = 1'b0;

    descending_time_record_sorter #(
        .DEPTH    (DEPTH),
        .TAG_BITS (TAG_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .result_strobe (result_strobe),
        .result        (result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Insert one record into the sorted store; on the last one, queue the whole list.
    task automatic predict_record(input in_word_t w);
        record_t   rec;
        int        slot;
        out_word_t r;
        rec.stamp = w.mod_time;
        rec.tag   = w.entry_tag & TAG_KEEP;
        if (held_records.size() >= DEPTH)
            records_dropped = 1'b1;
        else
        begin
            slot = 0;
            // go past every held key that is newer or equal, so ties keep arrival order
            while (slot < held_records.size() && held_records[slot].stamp >= rec.stamp)
                slot++;
            held_records.insert(slot, rec);
        end
        if (w.last_entry)
        begin
            foreach (held_records[k])
            begin
                r.sorted_time = held_records[k].stamp;
                r.sorted_tag  = held_records[k].tag;
                r.last_out    = (k == held_records.size() - 1);
                r.overflow    = records_dropped;
                sorted_due.push_back(r);
                results_due++;
            end
            held_records.delete();
            records_dropped = 1'b0;
        end
    endtask

    task automatic add_record(input logic [TIME_W-1:0] stamp, input logic [TAG_W-1:0] tag,
                              input bit last);
        send_slot_t s;
        s.word.mod_time   = stamp;
        s.word.entry_tag  = tag;
        s.word.last_entry = last;
        s.idle_pct        = cur_idle;
        s.drain_first     = hold_next;
        hold_next         = 1'b0;
        records_to_send.push_back(s);
    endtask

    function automatic logic [TIME_W-1:0] pick_stamp(input key_style_t style);
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        case (style)
            KEYS_TIED:  return TIME_W'($urandom_range(3));
            KEYS_TOP:   return TIME_MAX - TIME_W'($urandom_range(3));
            KEYS_EDGES: return ($urandom_range(1) != 0) ? TIME_MAX : '0;
            default:    return raw[TIME_W-1:0];
        endcase
    endfunction

    // Driver: present queued words, hold until taken, pause when asked.
    always @(posedge clk)
    begin
        send_slot_t sent;
        logic       take;
        logic       raise;
        take = rst_n && start && !busy;
        if (take)
        begin
            sent = records_to_send.pop_front();
            predict_record(sent.word);
        end
        raise = start && !take;
        if (!raise && rst_n && records_to_send.size() > 0)
        begin
            if (records_to_send[0].drain_first && results_due != results_seen)
                raise = 1'b0;
            else
                raise = ($urandom_range(99) >= records_to_send[0].idle_pct);
        end
        start <= raise;
        if (raise)
            item <= records_to_send[0].word;
    end

    // Monitor: check each result word against the oldest one due.
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && result_strobe)
        begin
            results_seen <= results_seen + 1;
            if (sorted_due.size() == 0)
            begin
                $display("%0t: unexpected word: time %h tag %h last %b ovf %b", $time,
                         result.sorted_time, result.sorted_tag, result.last_out,
                         result.overflow);
                errors++;
            end
            else
            begin
                want = sorted_due.pop_front();
                if (result.sorted_time !== want.sorted_time ||
                    result.sorted_tag !== want.sorted_tag ||
                    result.last_out !== want.last_out ||
                    result.overflow !== want.overflow)
                begin
                    $display("%0t: expected time %h tag %h last %b ovf %b, got time %h tag %h last %b ovf %b",
                             $time, want.sorted_time, want.sorted_tag, want.last_out,
                             want.overflow, result.sorted_time, result.sorted_tag,
                             result.last_out, result.overflow);
                    errors++;
                end
            end
        end
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("descending_time_record_sorter: mismatch");
            $finish;
        end
    end

    initial
    begin
        int         queued;
        int         len;
        int         pick;
        key_style_t style;

        // single records at both extremes
        add_record('0, '0, 1'b1);
        add_record(TIME_MAX, '1, 1'b1);
        // ascending arrival, fully reversed on output
        add_record(34'd1, 16'h000a, 1'b0);
        add_record(34'd2, 16'h000b, 1'b0);
        add_record(34'd3, 16'h000c, 1'b1);
        // equal keys keep arrival order
        add_record(34'd5, 16'h0001, 1'b0);
        add_record(34'd5, 16'h0002, 1'b0);
        add_record(34'd9, 16'h0003, 1'b0);
        add_record(34'd5, 16'h0004, 1'b0);
        add_record(34'd0, 16'h0005, 1'b1);
        // ties at the top key around a zero
        add_record(TIME_MAX, 16'h1111, 1'b0);
        add_record('0, 16'h2222, 1'b0);
        add_record(TIME_MAX, 16'h3333, 1'b0);
        add_record(TIME_MAX - 1, 16'h4444, 1'b1);
        // alternating bit patterns
        add_record(34'h2aaaaaaaa, 16'h5555, 1'b0);
        add_record(34'h155555555, 16'haaaa, 1'b1);

        // random lists: mostly short, some around and past a full store
        queued = 0;
        while (queued < 480)
        begin
            if (queued >= 160 && cur_idle == 29)
            begin
                cur_idle  = 75;
                hold_next = 1'b1;
            end
            else if (queued >= 320 && cur_idle == 75)
            begin
                cur_idle  = 0;
                hold_next = 1'b1;
            end
            if ($urandom_range(9) == 0)
                hold_next = 1'b1;
            pick = $urandom_range(9);
            if (pick == 0)
                len = $urandom_range(DEPTH + 4, DEPTH - 2);
            else if (pick == 1)
                len = DEPTH + $urandom_range(1);
            else
                len = $urandom_range(12, 1);
            style = key_style_t'($urandom_range(3));
            for (int n = 0; n < len; n++)
                add_record(pick_stamp(style), TAG_W'($urandom()), n == len - 1);
            queued += len;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // wait for every word to be taken and every result to arrive
        while (records_to_send.size() != 0 || start)
            @(posedge clk);
        while (results_due != results_seen)
            @(posedge clk);
        repeat (2 * DEPTH + 8) @(posedge clk);
        if (errors == 0 && sorted_due.size() == 0)
            $display("descending_time_record_sorter: match");
        else
            $display("descending_time_record_sorter: mismatch");
        $finish;
    end

endmodule
